// File: design/load_store_unit_core_defines.svh
// ----------------------------------------------------------------------------
// Load/store unit core - assertion macros
// Shared property wrappers for the checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef LOAD_STORE_UNIT_CORE_DEFINES_SVH
`define LOAD_STORE_UNIT_CORE_DEFINES_SVH

// same-cycle implication
`define LSU_CHK_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("load/store unit check failed");

// next-cycle implication
`define LSU_CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("load/store unit check failed");

`endif

// File: design/lsu_pkg.sv
// ----------------------------------------------------------------------------
// Load/store unit package
// Command codes, sequencer states, decode and register index helpers.
// ----------------------------------------------------------------------------
package lsu_pkg;

   localparam int REG_COUNT_DEF = 8;
   localparam int MEM_BYTES_DEF = 65536;
   localparam int ADDR_W        = 16;
   localparam int ADDR_SPAN     = 1 << ADDR_W;

   typedef enum logic [3:0] {
      CMD_LDB  = 4'd0,
      CMD_LDW  = 4'd1,
      CMD_LDBR = 4'd2,
      CMD_LDWR = 4'd3,
      CMD_LDI  = 4'd4,
      CMD_LEA  = 4'd5,
      CMD_MOV  = 4'd6,
      CMD_STB  = 4'd7,
      CMD_STW  = 4'd8,
      CMD_STBR = 4'd9,
      CMD_STWR = 4'd10,
      CMD_PUSH = 4'd11,
      CMD_POP  = 4'd12
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_ADDR,
      ST_QUO,
      ST_MEM,
      ST_LOAD,
      ST_WRT,
      ST_BASE
   } state_type;

   typedef struct packed {
      logic wr_reg;
      logic wr_base;
      logic mem;
      logic store;
      logic word;
   } op_ctrl_type;

   function automatic op_ctrl_type decode_op(logic [3:0] cmd);
      op_ctrl_type ctl;
      cmd_type     c;
      c           = cmd_type'(cmd);
      ctl.wr_reg  = c inside {CMD_LDB, CMD_LDW, CMD_LDBR, CMD_LDWR, CMD_LDI, CMD_LEA,
                              CMD_MOV, CMD_POP};
      ctl.wr_base = c inside {CMD_PUSH, CMD_POP};
      ctl.store   = c inside {CMD_STB, CMD_STW, CMD_STBR, CMD_STWR, CMD_PUSH};
      ctl.mem     = ctl.store || (c inside {CMD_LDB, CMD_LDW, CMD_LDBR, CMD_LDWR, CMD_LEA,
                                            CMD_POP});
      ctl.word    = c inside {CMD_LDW, CMD_LDWR, CMD_LEA, CMD_STW, CMD_STWR, CMD_PUSH,
                              CMD_POP};
      return ctl;
   endfunction

   // index modulo count, for 3-bit indices and counts of 2 to 16
   function automatic logic [3:0] reg_sel(logic [2:0] idx, int unsigned count);
      logic [3:0] v;
      v = {1'b0, idx};
      for (int i = 0; i < 4; i++) begin
         if ({1'b0, v} >= 5'(count)) begin
            v = v - 4'(count);
         end
      end
      return v;
   endfunction

endpackage

// File: design/load_store_unit_core.sv
// ----------------------------------------------------------------------------
// Load/store unit core
// Runs one load/store command per item against a register file and a
// little-endian byte memory, and reports the writes it made.
// ----------------------------------------------------------------------------
//
//   channel   ports                    handshake
//   --------  -----------------------  ----------------------------------
//   request   start, busy, req_*       taken when start && !busy
//   result    rsp_valid, rsp_*         one-cycle strobe, always taken
//
// An item runs from accept through FETCH, ADDR and BASE; defined codes add WRT,
// memory commands add one access of the single-port byte memory per byte, and
// loads add LOAD; each access is address reduction (ST_QUO), then ST_MEM.
// After reset a clearing pass zeroes both memories while busy is high. Results
// are registered in ST_BASE; the receiver cannot
// stall, so no output buffering beyond the result register is needed.
//
`include "load_store_unit_core_defines.svh"

module load_store_unit_core #(
   parameter int REG_COUNT = lsu_pkg::REG_COUNT_DEF,
   parameter int MEM_BYTES = lsu_pkg::MEM_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [3:0]                  req_command,
   input  logic [2:0]                  req_target_reg,
   input  logic [2:0]                  req_base_reg,
   input  logic [2:0]                  req_other_reg,
   input  logic signed [4:0]           req_offset_small,
   input  logic [7:0]                  req_immediate_byte,
   input  logic [lsu_pkg::ADDR_W-1:0]  req_program_counter,
   output logic                        rsp_valid,
   output logic                        rsp_reg_written,
   output logic [2:0]                  rsp_reg_index,
   output logic [15:0]                 rsp_reg_value,
   output logic                        rsp_base_written,
   output logic [15:0]                 rsp_base_value,
   output logic [1:0]                  rsp_mem_bytes,
   output logic [lsu_pkg::ADDR_W-1:0]  rsp_mem_address,
   output logic [15:0]                 rsp_mem_data
);
   import lsu_pkg::*;

   localparam int RW    = $clog2(REG_COUNT);
   localparam int AW    = $clog2(MEM_BYTES);
   localparam int RECIP = ADDR_SPAN / MEM_BYTES;
   localparam int QW    = $clog2(RECIP) + 1;
   localparam logic [QW-1:0]     RECIP_Q = QW'(RECIP);
   localparam logic [ADDR_W:0]   MEM_N   = (ADDR_W + 1)'(MEM_BYTES);
   localparam logic [AW-1:0]     CLR_END = AW'(MEM_BYTES - 1);
   localparam logic [AW-1:0]     RF_END  = AW'(REG_COUNT);

   // storage
   logic [15:0] rf_mem [REG_COUNT];
   logic [7:0]  byte_mem [MEM_BYTES];

   // memory ports
   logic [RW-1:0]  rf_ra_a, rf_ra_b, rf_wa;
   logic           rf_we;
   logic [15:0]    rf_wd;
   logic [15:0]    rf_rd_a_ff, rf_rd_b_ff;
   logic [AW-1:0]  mem_addr;
   logic           mem_we;
   logic [7:0]     mem_wd;
   logic [7:0]     mem_rd_ff;

   // control
   state_type      state_ff, state_in;
   logic [AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // item payload
   logic [3:0]         cmd_ff, cmd_in;
   logic [RW-1:0]      t_ff, t_in, b_ff, b_in, o_ff, o_in;
   logic [4:0]         off_ff, off_in;
   logic [7:0]         imm_ff, imm_in;
   logic [ADDR_W-1:0]  pc_ff, pc_in;
   logic [15:0]        rb_ff, rb_in, ro_ff, ro_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in, ma_ff, ma_in;
   logic [15:0]        data_ff, data_in, val_ff, val_in;
   logic [QW-1:0]      q_ff, q_in;
   logic               hi_ff, hi_in;

   // result register
   logic               rsp_rw_ff, rsp_rw_in, rsp_bw_ff, rsp_bw_in;
   logic [2:0]         rsp_ri_ff, rsp_ri_in;
   logic [15:0]        rsp_rv_ff, rsp_rv_in, rsp_bv_ff, rsp_bv_in, rsp_md_ff, rsp_md_in;
   logic [1:0]         rsp_mb_ff, rsp_mb_in;
   logic [ADDR_W-1:0]  rsp_ma_ff, rsp_ma_in;

   // helpers
   op_ctrl_type               ctl;
   logic [3:0]                t_sel, b_sel, o_sel;
   logic [ADDR_W+QW-1:0]      prod;
   logic [ADDR_W:0]           qn, rem, rem_fix;
   logic [AW-1:0]             mem_cell;
   logic [15:0]               off16, bval;

   assign ctl   = decode_op(cmd_ff);
   assign t_sel = reg_sel(req_target_reg, REG_COUNT);
   assign b_sel = reg_sel(req_base_reg, REG_COUNT);
   assign o_sel = reg_sel(req_other_reg, REG_COUNT);
   assign off16 = {{11{off_ff[4]}}, off_ff};

   // address modulo MEM_BYTES: reciprocal estimate (registered), then one fix-up
   assign prod     = (ADDR_W + QW)'(addr_ff) * (ADDR_W + QW)'(RECIP_Q);
   assign qn       = (ADDR_W + 1)'((ADDR_W + 1)'(q_ff) * MEM_N);
   assign rem      = {1'b0, addr_ff} - qn;
   assign rem_fix  = (rem >= MEM_N) ? (rem - MEM_N) : rem;
   assign mem_cell = rem_fix[AW-1:0];

   // base value: push leaves rb - 2, pop rb + 2; pop into its own stack pointer ends at loaded word plus one
   always_comb begin
      if (cmd_type'(cmd_ff) == CMD_POP) begin
         bval = (t_ff == b_ff) ? (val_ff + 16'd1) : (rb_ff + 16'd2);
      end else begin
         bval = rb_ff - 16'd2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      t_ff      <= t_in;
      b_ff      <= b_in;
      o_ff      <= o_in;
      off_ff    <= off_in;
      imm_ff    <= imm_in;
      pc_ff     <= pc_in;
      rb_ff     <= rb_in;
      ro_ff     <= ro_in;
      addr_ff   <= addr_in;
      ma_ff     <= ma_in;
      data_ff   <= data_in;
      val_ff    <= val_in;
      q_ff      <= q_in;
      hi_ff     <= hi_in;
      rsp_rw_ff <= rsp_rw_in;
      rsp_ri_ff <= rsp_ri_in;
      rsp_rv_ff <= rsp_rv_in;
      rsp_bw_ff <= rsp_bw_in;
      rsp_bv_ff <= rsp_bv_in;
      rsp_mb_ff <= rsp_mb_in;
      rsp_ma_ff <= rsp_ma_in;
      rsp_md_ff <= rsp_md_in;
   end

   // register file: two read ports, one write port
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_wa] <= rf_wd;
      end
      rf_rd_a_ff <= rf_mem[rf_ra_a];
      rf_rd_b_ff <= rf_mem[rf_ra_b];
   end

   // byte memory: single port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_mem[mem_addr] <= mem_wd;
      end
      mem_rd_ff <= byte_mem[mem_addr];
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = 1'b0;
      cmd_in       = cmd_ff;
      t_in         = t_ff;
      b_in         = b_ff;
      o_in         = o_ff;
      off_in       = off_ff;
      imm_in       = imm_ff;
      pc_in        = pc_ff;
      rb_in        = rb_ff;
      ro_in        = ro_ff;
      addr_in      = addr_ff;
      ma_in        = ma_ff;
      data_in      = data_ff;
      val_in       = val_ff;
      q_in         = q_ff;
      hi_in        = hi_ff;
      rsp_rw_in    = rsp_rw_ff;
      rsp_ri_in    = rsp_ri_ff;
      rsp_rv_in    = rsp_rv_ff;
      rsp_bw_in    = rsp_bw_ff;
      rsp_bv_in    = rsp_bv_ff;
      rsp_mb_in    = rsp_mb_ff;
      rsp_ma_in    = rsp_ma_ff;
      rsp_md_in    = rsp_md_ff;
      rf_ra_a      = t_ff;
      rf_ra_b      = o_ff;
      rf_we        = 1'b0;
      rf_wa        = t_ff;
      rf_wd        = val_ff;
      mem_addr     = mem_cell;
      mem_we       = 1'b0;
      mem_wd       = 8'h00;

      case (state_ff)
         ST_CLEAR: begin
            mem_addr   = clr_cnt_ff;
            mem_we     = 1'b1;
            rf_wa      = clr_cnt_ff[RW-1:0];
            rf_wd      = 16'h0000;
            rf_we      = (clr_cnt_ff < RF_END);
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == CLR_END) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rf_ra_a = b_sel[RW-1:0];
            rf_ra_b = o_sel[RW-1:0];
            if (start) begin
               cmd_in   = req_command;
               t_in     = t_sel[RW-1:0];
               b_in     = b_sel[RW-1:0];
               o_in     = o_sel[RW-1:0];
               off_in   = req_offset_small;
               imm_in   = req_immediate_byte;
               pc_in    = req_program_counter;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rb_in    = rf_rd_a_ff;
            ro_in    = rf_rd_b_ff;
            rf_ra_a  = t_ff;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            // rf_rd_a_ff now holds the target register
            case (cmd_type'(cmd_ff))
               CMD_LDB, CMD_LDW, CMD_STB, CMD_STW: addr_in = rb_ff + off16;
               CMD_LDBR, CMD_LDWR, CMD_STBR, CMD_STWR: addr_in = rb_ff + ro_ff;
               CMD_LEA:  addr_in = pc_ff + {8'h00, imm_ff};
               CMD_PUSH: addr_in = rb_ff - 16'd1;
               CMD_POP:  addr_in = rb_ff + 16'd1;
               default:  addr_in = '0;
            endcase
            ma_in   = addr_in;
            hi_in   = 1'b0;
            data_in = rf_rd_a_ff;
            if (cmd_type'(cmd_ff) == CMD_PUSH && t_ff == b_ff) begin
               data_in = rb_ff - 16'd1;
            end
            if (cmd_type'(cmd_ff) == CMD_LDI) begin
               val_in = {8'h00, imm_ff};
            end else begin
               val_in = ro_ff;
            end
            if (ctl.mem) begin
               state_in = ST_QUO;
            end else if (ctl.wr_reg) begin
               state_in = ST_WRT;
            end else begin
               state_in = ST_BASE;
            end
         end
         ST_QUO: begin
            q_in = prod[ADDR_W +: QW];
            if (hi_ff) begin
               val_in = {val_ff[15:8], mem_rd_ff};
            end
            state_in = ST_MEM;
         end
         ST_MEM: begin
            mem_we = ctl.store;
            mem_wd = hi_ff ? data_ff[15:8] : data_ff[7:0];
            if (ctl.word && !hi_ff) begin
               hi_in    = 1'b1;
               addr_in  = addr_ff + 16'd1;
               state_in = ST_QUO;
            end else if (ctl.store) begin
               state_in = ST_WRT;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            val_in   = ctl.word ? {mem_rd_ff, val_ff[7:0]} : {8'h00, mem_rd_ff};
            state_in = ST_WRT;
         end
         ST_WRT: begin
            rf_we    = ctl.wr_reg;
            rf_wa    = t_ff;
            rf_wd    = val_ff;
            state_in = ST_BASE;
         end
         ST_BASE: begin
            rf_we        = ctl.wr_base;
            rf_wa        = b_ff;
            rf_wd        = bval;
            rsp_valid_in = 1'b1;
            rsp_rw_in    = ctl.wr_reg;
            rsp_ri_in    = ctl.wr_reg ? 3'(t_ff) : 3'd0;
            rsp_rv_in    = ctl.wr_reg ? val_ff : 16'h0000;
            rsp_bw_in    = ctl.wr_base;
            rsp_bv_in    = ctl.wr_base ? bval : 16'h0000;
            rsp_mb_in    = ctl.store ? (ctl.word ? 2'd2 : 2'd1) : 2'd0;
            rsp_ma_in    = ctl.store ? ma_ff : '0;
            if (!ctl.store) begin
               rsp_md_in = 16'h0000;
            end else if (ctl.word) begin
               rsp_md_in = data_ff;
            end else begin
               rsp_md_in = {8'h00, data_ff[7:0]};
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reg_written  = rsp_rw_ff;
   assign rsp_reg_index    = rsp_ri_ff;
   assign rsp_reg_value    = rsp_rv_ff;
   assign rsp_base_written = rsp_bw_ff;
   assign rsp_base_value   = rsp_bv_ff;
   assign rsp_mem_bytes    = rsp_mb_ff;
   assign rsp_mem_address  = rsp_ma_ff;
   assign rsp_mem_data     = rsp_md_ff;

   `LSU_CHK_NEXT(a_accept_fetch, clock, reset, start && !busy, state_ff == ST_FETCH)
   `LSU_CHK_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `LSU_CHK_SAME(a_strobe_after_base, clock, reset, rsp_valid, $past(state_ff == ST_BASE))
   `LSU_CHK_SAME(a_mem_write_phase, clock, reset, mem_we, state_ff == ST_CLEAR || state_ff == ST_MEM)
   `LSU_CHK_SAME(a_base_only_stack, clock, reset, rsp_valid && rsp_base_written, rsp_mem_bytes == 2'd2 || rsp_reg_written)

endmodule

// File: tb/sv/tb_load_store_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load/store unit core testbench
// Drives load/store commands through the start/busy port and checks every
// reported register and memory write against a shadow register file and a
// shadow byte memory. A directed table runs first, then weighted random
// commands with push/pop pairs and random idle gaps on the request side.
// ----------------------------------------------------------------------------
module tb_load_store_unit_core;
   import lsu_pkg::*;

   localparam int REG_COUNT  = REG_COUNT_DEF;
   localparam int MEM_BYTES  = MEM_BYTES_DEF;
   localparam int ITEM_TOTAL = 1150;
   localparam int ROW_COUNT  = 22;

   // codes the block leaves undefined: no write at all
   localparam logic [3:0] CMD_UNDEF_FIRST = 4'd13;
   localparam logic [3:0] CMD_UNDEF_MID   = 4'd14;
   localparam logic [3:0] CMD_UNDEF_LAST  = 4'd15;

   typedef struct packed {
      logic [3:0]        command;
      logic [2:0]        target;
      logic [2:0]        base;
      logic [2:0]        other;
      logic signed [4:0] offset;
      logic [7:0]        imm;
      logic [15:0]       pc;
   } lsu_item_type;

   typedef struct packed {
      logic        reg_written;
      logic [2:0]  reg_index;
      logic [15:0] reg_value;
      logic        base_written;
      logic [15:0] base_value;
      logic [1:0]  mem_bytes;
      logic [15:0] mem_address;
      logic [15:0] mem_data;
   } lsu_result_type;

   typedef struct packed {
      lsu_item_type   item;
      logic           typed;
      lsu_result_type result;
   } lsu_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [3:0]  req_command;
   logic [2:0]  req_target_reg;
   logic [2:0]  req_base_reg;
   logic [2:0]  req_other_reg;
   logic signed [4:0] req_offset_small;
   logic [7:0]  req_immediate_byte;
   logic [15:0] req_program_counter;
   logic        rsp_valid;
   logic        rsp_reg_written;
   logic [2:0]  rsp_reg_index;
   logic [15:0] rsp_reg_value;
   logic        rsp_base_written;
   logic [15:0] rsp_base_value;
   logic [1:0]  rsp_mem_bytes;
   logic [15:0] rsp_mem_address;
   logic [15:0] rsp_mem_data;

   logic [15:0] shadow_regs [0:REG_COUNT-1];
   logic [7:0]  shadow_mem  [0:MEM_BYTES-1];
   lsu_result_type writes_due [$];
   lsu_row_type    directed_rows [0:ROW_COUNT-1];
   int unsigned mismatch_count = 0;
   int unsigned calm_left = 0;

   load_store_unit_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_target_reg      (req_target_reg),
      .req_base_reg        (req_base_reg),
      .req_other_reg       (req_other_reg),
      .req_offset_small    (req_offset_small),
      .req_immediate_byte  (req_immediate_byte),
      .req_program_counter (req_program_counter),
      .rsp_valid           (rsp_valid),
      .rsp_reg_written     (rsp_reg_written),
      .rsp_reg_index       (rsp_reg_index),
      .rsp_reg_value       (rsp_reg_value),
      .rsp_base_written    (rsp_base_written),
      .rsp_base_value      (rsp_base_value),
      .rsp_mem_bytes       (rsp_mem_bytes),
      .rsp_mem_address     (rsp_mem_address),
      .rsp_mem_data        (rsp_mem_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] read_byte(logic [15:0] addr);
      return shadow_mem[addr % MEM_BYTES];
   endfunction

   // little-endian, second byte wraps at 16 bits
   function automatic logic [15:0] read_word(logic [15:0] addr);
      return {read_byte(addr + 16'd1), read_byte(addr)};
   endfunction

   // Executes one command on the shadow state and returns the writes it makes.
   function automatic lsu_result_type execute_command(lsu_item_type it);
      lsu_result_type r;
      int unsigned t, b, o;
      logic [15:0] a_off, a_idx;
      r     = '0;
      t     = it.target % REG_COUNT;
      b     = it.base % REG_COUNT;
      o     = it.other % REG_COUNT;
      a_off = shadow_regs[b] + {{11{it.offset[4]}}, it.offset};
      a_idx = shadow_regs[b] + shadow_regs[o];
      case (it.command)
         CMD_LDB: begin
            r.reg_written = 1'b1;
            r.reg_value   = {8'h00, read_byte(a_off)};
         end
         CMD_LDW: begin
            r.reg_written = 1'b1;
            r.reg_value   = read_word(a_off);
         end
         CMD_LDBR: begin
            r.reg_written = 1'b1;
            r.reg_value   = {8'h00, read_byte(a_idx)};
         end
         CMD_LDWR: begin
            r.reg_written = 1'b1;
            r.reg_value   = read_word(a_idx);
         end
         CMD_LDI: begin
            r.reg_written = 1'b1;
            r.reg_value   = {8'h00, it.imm};
         end
         CMD_LEA: begin
            r.reg_written = 1'b1;
            r.reg_value   = read_word(it.pc + {8'h00, it.imm});
         end
         CMD_MOV: begin
            r.reg_written = 1'b1;
            r.reg_value   = shadow_regs[o];
         end
         CMD_STB: begin
            r.mem_bytes   = 2'd1;
            r.mem_address = a_off;
            r.mem_data    = {8'h00, shadow_regs[t][7:0]};
         end
         CMD_STW: begin
            r.mem_bytes   = 2'd2;
            r.mem_address = a_off;
            r.mem_data    = shadow_regs[t];
         end
         CMD_STBR: begin
            r.mem_bytes   = 2'd1;
            r.mem_address = a_idx;
            r.mem_data    = {8'h00, shadow_regs[t][7:0]};
         end
         CMD_STWR: begin
            r.mem_bytes   = 2'd2;
            r.mem_address = a_idx;
            r.mem_data    = shadow_regs[t];
         end
         CMD_PUSH: begin
            // pushing the stack pointer stores its decremented value
            shadow_regs[b] = shadow_regs[b] - 16'd1;
            r.mem_bytes    = 2'd2;
            r.mem_address  = shadow_regs[b];
            r.mem_data     = shadow_regs[t];
            r.base_written = 1'b1;
            r.base_value   = shadow_regs[b] - 16'd1;
         end
         CMD_POP: begin
            // popping into the stack pointer ends at loaded word + 1
            shadow_regs[b] = shadow_regs[b] + 16'd1;
            r.reg_written  = 1'b1;
            r.reg_value    = read_word(shadow_regs[b]);
            shadow_regs[t] = r.reg_value;
            r.base_written = 1'b1;
            r.base_value   = shadow_regs[b] + 16'd1;
         end
         default: ;
      endcase
      if (r.mem_bytes != 2'd0) begin
         shadow_mem[r.mem_address % MEM_BYTES] = r.mem_data[7:0];
         if (r.mem_bytes == 2'd2) begin
            shadow_mem[16'(r.mem_address + 16'd1) % MEM_BYTES] = r.mem_data[15:8];
         end
      end
      if (r.reg_written) begin
         shadow_regs[t] = r.reg_value;
         r.reg_index    = 3'(t);
      end
      if (r.base_written) begin
         shadow_regs[b] = r.base_value;
      end
      return r;
   endfunction

   function automatic lsu_item_type random_item();
      lsu_item_type it;
      int unsigned  sel;
      sel       = $urandom_range(0, 99);
      it.target = 3'($urandom);
      it.base   = 3'($urandom);
      it.other  = 3'($urandom);
      it.offset = 5'($urandom);
      it.imm    = 8'($urandom);
      // keep half the lea reads near the live part of memory
      it.pc     = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 511)) : 16'($urandom);
      if (sel < 4) begin
         it.command = 4'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
      end else if (sel < 18) begin
         it.command = CMD_LDI;
      end else begin
         it.command = 4'($urandom_range(CMD_LDB, CMD_POP));
      end
      return it;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input lsu_item_type it, input lsu_result_type want);
      int unsigned gap;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(16, 64);
         end
         gap = $urandom_range(0, 15);
      end
      writes_due.push_back(want);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start               <= 1'b1;
      req_command         <= it.command;
      req_target_reg      <= it.target;
      req_base_reg        <= it.base;
      req_other_reg       <= it.other;
      req_offset_small    <= it.offset;
      req_immediate_byte  <= it.imm;
      req_program_counter <= it.pc;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (writes_due.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      lsu_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (writes_due.size() == 0) begin
            $error("result item with no command pending");
            mismatch_count++;
         end else begin
            want = writes_due.pop_front();
            check_field("rsp_reg_written", 16'(want.reg_written), 16'(rsp_reg_written));
            check_field("rsp_reg_index", 16'(want.reg_index), 16'(rsp_reg_index));
            check_field("rsp_reg_value", want.reg_value, rsp_reg_value);
            check_field("rsp_base_written", 16'(want.base_written), 16'(rsp_base_written));
            check_field("rsp_base_value", want.base_value, rsp_base_value);
            check_field("rsp_mem_bytes", 16'(want.mem_bytes), 16'(rsp_mem_bytes));
            check_field("rsp_mem_address", want.mem_address, rsp_mem_address);
            check_field("rsp_mem_data", want.mem_data, rsp_mem_data);
         end
      end
   end

   initial begin
      lsu_item_type   it;
      lsu_result_type want;
      int unsigned    sent;
      logic           paused;
      reset               = 1'b1;
      start               = 1'b0;
      req_command         = '0;
      req_target_reg      = '0;
      req_base_reg        = '0;
      req_other_reg       = '0;
      req_offset_small    = '0;
      req_immediate_byte  = '0;
      req_program_counter = '0;
      for (int i = 0; i < REG_COUNT; i++) shadow_regs[i] = '0;
      for (int i = 0; i < MEM_BYTES; i++) shadow_mem[i] = '0;

      // command, target, base, other, offset, imm, pc | typed | expected writes
      directed_rows = '{
         '{'{CMD_LDW,  3'd0, 3'd1, 3'd0, -5'sd16, 8'h00, 16'h0000}, 1'b1,
           '{1'b1, 3'd0, 16'h0000, 1'b0, 16'h0000, 2'd0, 16'h0000, 16'h0000}},
         '{'{CMD_LDI,  3'd1, 3'd0, 3'd0, 5'sd0,   8'hFF, 16'h0000}, 1'b1,
           '{1'b1, 3'd1, 16'h00FF, 1'b0, 16'h0000, 2'd0, 16'h0000, 16'h0000}},
         '{'{CMD_LDI,  3'd2, 3'd0, 3'd0, 5'sd0,   8'hAB, 16'h0000}, 1'b1,
           '{1'b1, 3'd2, 16'h00AB, 1'b0, 16'h0000, 2'd0, 16'h0000, 16'h0000}},
         '{'{CMD_STB,  3'd2, 3'd1, 3'd0, 5'sd15,  8'h00, 16'h0000}, 1'b1,
           '{1'b0, 3'd0, 16'h0000, 1'b0, 16'h0000, 2'd1, 16'h010E, 16'h00AB}},
         '{'{CMD_STB,  3'd1, 3'd1, 3'd0, -5'sd16, 8'h00, 16'h0000}, 1'b1,
           '{1'b0, 3'd0, 16'h0000, 1'b0, 16'h0000, 2'd1, 16'h00EF, 16'h00FF}},
         '{'{CMD_LDW,  3'd3, 3'd1, 3'd0, 5'sd15,  8'h00, 16'h0000}, 1'b0, '0},
         '{'{CMD_LDB,  3'd4, 3'd1, 3'd0, -5'sd16, 8'h00, 16'h0000}, 1'b0, '0},
         '{'{CMD_MOV,  3'd5, 3'd0, 3'd4, 5'sd0,   8'h00, 16'h0000}, 1'b0, '0},
         '{'{CMD_STW,  3'd5, 3'd2, 3'd0, 5'sd0,   8'h00, 16'h0000}, 1'b0, '0},
         '{'{CMD_LDBR, 3'd6, 3'd1, 3'd2, 5'sd0,   8'h00, 16'h0000}, 1'b0, '0},
         '{'{CMD_LDWR, 3'd6, 3'd2, 3'd7, 5'sd0,   8'h00, 16'h0000}, 1'b0, '0},
         '{'{CMD_STBR, 3'd3, 3'd2, 3'd1, 5'sd0,   8'h00, 16'h0000}, 1'b0, '0},
         '{'{CMD_STWR, 3'd6, 3'd1, 3'd2, 5'sd0,   8'h00, 16'h0000}, 1'b0, '0},
         '{'{CMD_LEA,  3'd7, 3'd0, 3'd0, 5'sd0,   8'hFF, 16'hFFFF}, 1'b0, '0},
         // push of the stack pointer from zero: store wraps past 0xFFFF
         '{'{CMD_PUSH, 3'd0, 3'd0, 3'd0, 5'sd0,   8'h00, 16'h0000}, 1'b1,
           '{1'b0, 3'd0, 16'h0000, 1'b1, 16'hFFFE, 2'd2, 16'hFFFF, 16'hFFFF}},
         '{'{CMD_POP,  3'd0, 3'd0, 3'd0, 5'sd0,   8'h00, 16'h0000}, 1'b0, '0},
         '{'{CMD_PUSH, 3'd5, 3'd6, 3'd0, 5'sd0,   8'h00, 16'h0000}, 1'b0, '0},
         '{'{CMD_POP,  3'd7, 3'd6, 3'd0, 5'sd0,   8'h00, 16'h0000}, 1'b0, '0},
         '{'{CMD_UNDEF_FIRST, 3'd7, 3'd7, 3'd7, -5'sd1, 8'hFF, 16'hFFFF}, 1'b1, '0},
         '{'{CMD_UNDEF_MID,   3'd3, 3'd5, 3'd1, 5'sd7,  8'h5A, 16'h1234}, 1'b1, '0},
         '{'{CMD_UNDEF_LAST,  3'd0, 3'd1, 3'd2, 5'sd0,  8'h00, 16'h0000}, 1'b1, '0},
         '{'{CMD_LEA,  3'd0, 3'd0, 3'd0, 5'sd0,   8'h00, 16'h0000}, 1'b0, '0}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < ROW_COUNT; i++) begin
         want = execute_command(directed_rows[i].item);
         if (directed_rows[i].typed) want = directed_rows[i].result;
         send_item(directed_rows[i].item, want);
      end
      start <= 1'b0;
      wait_drained();
      @(negedge clock);

      sent   = ROW_COUNT;
      paused = 1'b0;
      while (sent < ITEM_TOTAL) begin
         if (!paused && sent >= ITEM_TOTAL / 2) begin
            // hold off until the block has reported every item
            start <= 1'b0;
            wait_drained();
            @(negedge clock);
            paused = 1'b1;
         end
         it = random_item();
         if ($urandom_range(0, 99) < 15) begin
            // push then pop on one stack pointer
            it.command = CMD_PUSH;
            want = execute_command(it);
            send_item(it, want);
            it.command = CMD_POP;
            it.target  = 3'($urandom);
            want = execute_command(it);
            send_item(it, want);
            sent += 2;
         end else begin
            want = execute_command(it);
            send_item(it, want);
            sent++;
         end
      end
      start <= 1'b0;
      wait_drained();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // 10 ms: clearing pass plus slowest item rate with the longest gaps, many times over
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
